/* src/distinct_ssid_counter_assert.svh */
// Assertion macros used by the checker file of the distinct SSID counter.
// Each macro expands to one labeled concurrent assertion that is disabled
// while the asynchronous reset is asserted.
`ifndef DISTINCT_SSID_COUNTER_ASSERT_SVH
`define DISTINCT_SSID_COUNTER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("distinct_ssid_counter: assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define DSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("distinct_ssid_counter: assertion failed");

`endif

/* src/dsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants of the distinct SSID counter
// Holds the item and result formats, the internal operation format passed
// from the front end to the back end, and the sizes of the name table.
// ----------------------------------------------------------------------------
package dsc_pkg;

	// Table and record sizes.
	localparam int MAX_NAME_BYTES = 32;
	localparam int TABLE_ENTRIES  = 32;
	localparam int QUEUE_DEPTH    = 4;

	localparam int ENTRY_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int BIDX_W  = $clog2(MAX_NAME_BYTES);
	localparam int LEN_W   = $clog2(MAX_NAME_BYTES + 1);
	localparam int ADDR_W  = ENTRY_W + BIDX_W;
	localparam int Q_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] SPACE_CODE = 8'h20;

	// Function codes of an input item.
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_BYTE  = 2'd1;
	localparam logic [1:0] FUNC_EMPTY = 2'd2;

	// Operation codes carried through the queue.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] ssid_byte;
		logic       last_byte;
		logic [7:0] rx_level;
	} item_t;

	typedef struct packed {
		logic [5:0] distinct_count;
		logic       hidden;
		logic       was_new;
		logic [7:0] entry_level;
		logic       dropped;
	} result_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ssid_byte;
		logic       last_byte;
		logic [7:0] rx_level;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* src/dsc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_front: input stage of the distinct SSID counter
// Registers each incoming item, decodes its function code into an operation
// and pushes it into the queue. Unused function codes are discarded here.
// ----------------------------------------------------------------------------
module dsc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  dsc_pkg::item_t     item,
	input  dsc_pkg::q_status_t q_status,
	output logic               push,
	output dsc_pkg::op_t       push_op
);
	import dsc_pkg::*;

	logic stage_valid_s1;
	op_t  stage_op_s1;
	logic accept;
	logic known;
	op_t  dec_op;

	// Decode the function code of the incoming item.
	always_comb begin
		dec_op.ssid_byte = item.ssid_byte;
		dec_op.last_byte = item.last_byte;
		dec_op.rx_level  = item.rx_level;
		dec_op.kind      = OP_START;
		known            = 1'b1;
		unique case (item.func)
			FUNC_START: dec_op.kind = OP_START;
			FUNC_BYTE:  dec_op.kind = OP_BYTE;
			FUNC_EMPTY: dec_op.kind = OP_EMPTY;
			default:    known = 1'b0;
		endcase
	end

	// The stage holds one operation until the queue has room for it.
	assign push       = stage_valid_s1 && !q_status.full;
	assign item_stall = stage_valid_s1 && q_status.full;
	assign accept     = item_valid && !item_stall;
	assign push_op    = stage_op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_s1 <= 1'b0;
		end else if (accept) begin
			stage_valid_s1 <= known;
		end else if (push) begin
			stage_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_op_s1 <= dec_op;
		end
	end

endmodule

/* src/dsc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_queue: operation queue between front end and back end
// A small first-in first-out buffer that lets the front end keep taking
// items while the back end searches the name table.
// ----------------------------------------------------------------------------
module dsc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dsc_pkg::op_t       push_op,
	input  logic               pop,
	output dsc_pkg::op_t       head_op,
	output dsc_pkg::q_status_t status
);
	import dsc_pkg::*;

	op_t                slot_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign status.full  = (count_q == Q_CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_op      = slot_q[rd_ptr_q];

	// Pointer and fill count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

/* src/dsc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_back: record assembly and name table search
// Collects record bytes, classifies finished records as hidden or visible,
// walks the name table for an exact match, updates or appends an entry, and
// holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module dsc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dsc_pkg::op_t       head_op,
	input  dsc_pkg::q_status_t q_status,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output dsc_pkg::result_t   result
);
	import dsc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_COPY = 3'd4;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic [LEN_W-1:0]  rec_len_q;
	logic              all_zero_q;
	logic              all_space_q;
	logic              overflow_q;
	logic [7:0]        level_q;
	logic [CNT_W-1:0]  ent_q;
	logic [BIDX_W-1:0] byte_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [7:0]        rec_buf_q  [MAX_NAME_BYTES];
	logic [7:0]        name_mem_q [TABLE_ENTRIES * MAX_NAME_BYTES];
	logic [LEN_W-1:0]  name_len_q [TABLE_ENTRIES];
	logic [7:0]        best_lvl_q [TABLE_ENTRIES];
	logic [7:0]        rd_data_q;

	logic              out_free;
	logic              store_byte;
	logic [LEN_W-1:0]  nxt_len;
	logic              nxt_zero;
	logic              nxt_space;
	logic              nxt_ovf;
	logic              rec_hidden;
	logic [ENTRY_W-1:0] ent_idx;
	logic [ENTRY_W-1:0] cnt_idx;
	logic [BIDX_W-1:0] last_idx;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        buf_byte;
	logic [7:0]        stored_lvl;
	logic [7:0]        min_lvl;
	logic              hit_done;
	logic              copy_done;

	assign out_free = !out_valid_q || !result_stall;
	assign pop      = (state_q == ST_IDLE) && !q_status.empty && out_free;

	// Running record state after the byte at the head of the queue.
	assign store_byte = (rec_len_q < LEN_W'(MAX_NAME_BYTES));
	assign nxt_len    = store_byte ? rec_len_q + 1'b1 : rec_len_q;
	assign nxt_zero   = all_zero_q && !(store_byte && (head_op.ssid_byte != 8'h00));
	assign nxt_space  = all_space_q && !(store_byte && (head_op.ssid_byte != SPACE_CODE));
	assign nxt_ovf    = overflow_q || !store_byte;
	assign rec_hidden = (nxt_len == '0) || nxt_zero || nxt_space;

	// Table addressing and comparison operands.
	assign ent_idx    = ent_q[ENTRY_W-1:0];
	assign cnt_idx    = entry_count_q[ENTRY_W-1:0];
	assign last_idx   = BIDX_W'(rec_len_q - 1'b1);
	assign rd_addr    = {ent_idx, byte_q};
	assign wr_addr    = {cnt_idx, byte_q};
	assign buf_byte   = rec_buf_q[byte_q];
	assign stored_lvl = best_lvl_q[ent_idx];
	assign min_lvl    = (level_q < stored_lvl) ? level_q : stored_lvl;
	assign hit_done   = (state_q == ST_CMP) && (rd_data_q == buf_byte) && (byte_q == last_idx);
	assign copy_done  = (state_q == ST_COPY) && (byte_q == last_idx);

	// Sequencer: record assembly, table walk and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			rec_len_q     <= '0;
			all_zero_q    <= 1'b1;
			all_space_q   <= 1'b1;
			overflow_q    <= 1'b0;
			level_q       <= '0;
			ent_q         <= '0;
			byte_q        <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head_op.kind)
							OP_START: begin
								entry_count_q <= '0;
								rec_len_q     <= '0;
								all_zero_q    <= 1'b1;
								all_space_q   <= 1'b1;
								overflow_q    <= 1'b0;
							end
							OP_EMPTY: begin
								rec_len_q   <= '0;
								all_zero_q  <= 1'b1;
								all_space_q <= 1'b1;
								overflow_q  <= 1'b0;
								out_valid_q <= 1'b1;
								out_q       <= '{distinct_count: 6'(entry_count_q),
									hidden: 1'b1, was_new: 1'b0,
									entry_level: 8'h00, dropped: 1'b0};
							end
							OP_BYTE: begin
								level_q <= head_op.rx_level;
								if (!head_op.last_byte) begin
									rec_len_q   <= nxt_len;
									all_zero_q  <= nxt_zero;
									all_space_q <= nxt_space;
									overflow_q  <= nxt_ovf;
								end else if (rec_hidden) begin
									// Hidden record: the table stays as it is.
									rec_len_q   <= '0;
									all_zero_q  <= 1'b1;
									all_space_q <= 1'b1;
									overflow_q  <= 1'b0;
									out_valid_q <= 1'b1;
									out_q       <= '{distinct_count: 6'(entry_count_q),
										hidden: 1'b1, was_new: 1'b0,
										entry_level: 8'h00, dropped: nxt_ovf};
								end else begin
									rec_len_q   <= nxt_len;
									all_zero_q  <= nxt_zero;
									all_space_q <= nxt_space;
									overflow_q  <= nxt_ovf;
									ent_q       <= '0;
									state_q     <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (ent_q == entry_count_q) begin
						if (entry_count_q < CNT_W'(TABLE_ENTRIES)) begin
							byte_q  <= '0;
							state_q <= ST_COPY;
						end else begin
							// Table full and no match: the name is dropped.
							rec_len_q   <= '0;
							all_zero_q  <= 1'b1;
							all_space_q <= 1'b1;
							overflow_q  <= 1'b0;
							out_valid_q <= 1'b1;
							out_q       <= '{distinct_count: 6'(entry_count_q),
								hidden: 1'b0, was_new: 1'b0,
								entry_level: 8'h00, dropped: 1'b1};
							state_q     <= ST_IDLE;
						end
					end else if (name_len_q[ent_idx] == rec_len_q) begin
						byte_q  <= '0;
						state_q <= ST_READ;
					end else begin
						ent_q <= ent_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rd_data_q != buf_byte) begin
						ent_q   <= ent_q + 1'b1;
						state_q <= ST_SCAN;
					end else if (hit_done) begin
						// Match: report the smaller of stored and new level.
						rec_len_q   <= '0;
						all_zero_q  <= 1'b1;
						all_space_q <= 1'b1;
						overflow_q  <= 1'b0;
						out_valid_q <= 1'b1;
						out_q       <= '{distinct_count: 6'(entry_count_q),
							hidden: 1'b0, was_new: 1'b0,
							entry_level: min_lvl, dropped: overflow_q};
						state_q     <= ST_IDLE;
					end else begin
						byte_q  <= byte_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_COPY: begin
					if (copy_done) begin
						entry_count_q <= entry_count_q + 1'b1;
						rec_len_q     <= '0;
						all_zero_q    <= 1'b1;
						all_space_q   <= 1'b1;
						overflow_q    <= 1'b0;
						out_valid_q   <= 1'b1;
						out_q         <= '{distinct_count: 6'(entry_count_q + 1'b1),
							hidden: 1'b0, was_new: 1'b1,
							entry_level: level_q, dropped: overflow_q};
						state_q       <= ST_IDLE;
					end else begin
						byte_q <= byte_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Record buffer: one byte written per stored record byte.
	always_ff @(posedge clk) begin
		if (pop && (head_op.kind == OP_BYTE) && store_byte) begin
			rec_buf_q[rec_len_q[BIDX_W-1:0]] <= head_op.ssid_byte;
		end
	end

	// Name memory: one write port for the copy, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ST_COPY) begin
			name_mem_q[wr_addr] <= buf_byte;
		end
		rd_data_q <= name_mem_q[rd_addr];
	end

	// Entry length and level registers.
	always_ff @(posedge clk) begin
		if (copy_done) begin
			name_len_q[cnt_idx] <= rec_len_q;
			best_lvl_q[cnt_idx] <= level_q;
		end else if (hit_done) begin
			best_lvl_q[ent_idx] <= min_lvl;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* src/distinct_ssid_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_ssid_counter: counts distinct visible SSIDs of a WLAN scan
// Top level: front end, operation queue and table back end.
// ----------------------------------------------------------------------------
// Items are taken one per cycle, while the queue is not full, into a
// four-deep queue; the back end handles each SSID byte that does not end a
// record, and each empty-record or start item, from its idle state. A record
// end walks the table of stored names: it scans the stored entries in turn,
// and for each entry whose length equals the record's it reads the name
// memory, then compares, byte by byte; a new name is copied in byte by byte.
// The result waits in an output register, so the queue keeps filling
// meanwhile. The table is cleared by a start item; no clearing pass exists.
module distinct_ssid_counter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  dsc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output dsc_pkg::result_t result
);
	import dsc_pkg::*;

	logic      push;
	op_t       push_op;
	logic      pop;
	op_t       head_op;
	q_status_t q_status;

	// Item decode and staging.
	dsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.push_op    (push_op)
	);

	// Queue between the two halves.
	dsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.status  (q_status)
	);

	// Record handling and table search.
	dsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_op      (head_op),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* src/dsc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_checker: port-level assertions for the distinct SSID counter
// Watches the result channel for transfer rules and field consistency.
// ----------------------------------------------------------------------------
`include "distinct_ssid_counter_assert.svh"

module dsc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input dsc_pkg::result_t result
);
	import dsc_pkg::*;

	// A stalled result stays offered and unchanged.
	`DSC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))

	// A hidden record never adds an entry and reports no level.
	`DSC_ASSERT_IMPLY(a_hidden_clean, clk, arst_n, result_valid && result.hidden, !result.was_new && (result.entry_level == 8'h00))

	// The distinct count never exceeds the table size.
	`DSC_ASSERT_IMPLY(a_count_bound, clk, arst_n, result_valid, result.distinct_count <= 6'(TABLE_ENTRIES))

	// A new entry implies at least one stored name.
	`DSC_ASSERT_IMPLY(a_new_nonzero, clk, arst_n, result_valid && result.was_new, result.distinct_count != 6'd0)

endmodule

bind distinct_ssid_counter dsc_checker u_dsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
